// File: sv/kbt_pkg.sv
`default_nettype none

package kbt_pkg;

	localparam int ENTRIES_DEF    = 32;
	localparam int MAX_LEN_DEF    = 255;
	localparam int MIN_LEN_DEF    = 100;
	localparam int KEY_BYTES_DEF  = 7;

	localparam int KEY_FIELD_BYTES = 7;
	localparam int KEY_W      = 56;
	localparam int TS_W       = 32;
	localparam int LEN_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int SLOT_W     = 5;
	localparam int CMD_W      = 2;
	localparam int STS_W      = 2;
	localparam int SLOT_BYTES = 256;
	localparam int BIDX_W     = 8;
	localparam int IN_DATA_W  = KEY_W + TS_W + LEN_W + BIDX_W + BYTE_W;
	localparam int OUT_DATA_W = 24;
	localparam logic [TS_W-1:0] TIME_INIT = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_WRITE  = 2'd2,
		CMD_READ   = 2'd3
	} kbt_cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK     = 2'd0,
		STS_MISS   = 2'd1,
		STS_REJECT = 2'd2
	} kbt_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_ACC,
		ST_ACC_RSP,
		ST_DONE
	} kbt_state_t;

	typedef struct packed {
		kbt_cmd_t           cmd;
		logic [KEY_W-1:0]   key;
		logic [TS_W-1:0]    ts;
		logic [LEN_W-1:0]   len;
		logic [BIDX_W-1:0]  bidx;
		logic [BYTE_W-1:0]  bval;
	} kbt_req_t;

	typedef struct packed {
		kbt_status_t        status;
		logic [SLOT_W-1:0]  slot;
		logic [LEN_W-1:0]   blen;
		logic [BYTE_W-1:0]  rbyte;
	} kbt_res_t;

	function automatic logic [KEY_W-1:0] key_mask(input int kb);
		int nb;
		nb = (kb > KEY_FIELD_BYTES) ? KEY_FIELD_BYTES : kb;
		return ~KEY_W'(0) << ((KEY_FIELD_BYTES - nb) * 8);
	endfunction

endpackage

`default_nettype wire

// File: sv/keyed_blob_table_oldest_evict.sv
// Keyed blob table, one beat in, one beat out. After reset the block sweeps
// both memories to zero and takes no beat until that is done. Lookup and
// store walk the entry memory one entry per cycle through its single read
// port; payload reads and writes pass through the ACC and ACC_RSP states. One
// command is worked at a time; a new beat is taken while an earlier result
// still sits in the output register.
`default_nettype none

module keyed_blob_table_oldest_evict import kbt_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int MAX_LEN   = MAX_LEN_DEF,
	parameter int MIN_LEN   = MIN_LEN_DEF,
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// key, timestamp, length, byte_index, byte_value
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// command
	input  wire logic [CMD_W-1:0]      s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// slot, blob_length, read_byte, zero pad
	output logic      [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic      [STS_W-1:0]      m_tuser
);

	kbt_req_t req;
	kbt_res_t res;
	logic     start;
	logic     res_valid;
	logic     res_ready;
	logic     core_ready;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [STS_W-1:0]      m_tuser_q;

	assign req.cmd  = kbt_cmd_t'(s_tuser);
	assign req.key  = s_tdata[KEY_W-1:0];
	assign req.ts   = s_tdata[KEY_W +: TS_W];
	assign req.len  = s_tdata[KEY_W+TS_W +: LEN_W];
	assign req.bidx = s_tdata[KEY_W+TS_W+LEN_W +: BIDX_W];
	assign req.bval = s_tdata[KEY_W+TS_W+LEN_W+BIDX_W +: BYTE_W];

	assign s_tready  = core_ready;
	assign start     = s_tvalid && core_ready;
	assign res_ready = !m_tvalid_q || m_tready;

	kbt_core #(
		.ENTRIES   (ENTRIES),
		.MAX_LEN   (MAX_LEN),
		.MIN_LEN   (MIN_LEN),
		.KEY_BYTES (KEY_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.ready     (core_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= OUT_DATA_W'({res.rbyte, res.blen, res.slot});
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// File: sv/kbt_ram.sv
`default_nettype none

module kbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: sv/kbt_core.sv
`default_nettype none

module kbt_core import kbt_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int MAX_LEN   = MAX_LEN_DEF,
	parameter int MIN_LEN   = MIN_LEN_DEF,
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire kbt_req_t req,
	output logic          ready,
	output logic          res_valid,
	input  wire logic     res_ready,
	output kbt_res_t      res
);

	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int PAY_DEPTH = ENTRIES * SLOT_BYTES;
	localparam int PAY_AW    = IDX_W + BIDX_W;
	localparam int META_W    = KEY_W + TS_W + LEN_W;
	localparam logic [KEY_W-1:0] KEY_MASK = key_mask(KEY_BYTES);
	localparam logic [IDX_W:0]   ENT_CNT  = (IDX_W+1)'(ENTRIES);
	localparam logic [PAY_AW-1:0] CLR_LAST = PAY_AW'(PAY_DEPTH - 1);

	kbt_state_t state_q, state_d;

	kbt_req_t          req_q;
	logic [PAY_AW-1:0] clr_q;
	logic [IDX_W:0]    addr_q;
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  chosen_q;
	logic [TS_W-1:0]   min_q;
	logic [LEN_W-1:0]  hit_len_q;
	logic              found_q;
	kbt_res_t          res_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	logic              m_we;
	logic [IDX_W-1:0]  m_waddr;
	logic [META_W-1:0] m_wdata;
	logic [IDX_W-1:0]  m_raddr;
	logic [META_W-1:0] m_rdata;
	logic              p_we;
	logic [PAY_AW-1:0] p_waddr;
	logic [BYTE_W-1:0] p_wdata;
	logic [PAY_AW-1:0] p_raddr;
	logic [BYTE_W-1:0] p_rdata;

	logic              issue;
	logic              len_ok;
	logic              key_hit;
	logic              scan_done;
	logic [KEY_W-1:0]  rd_key;
	logic [TS_W-1:0]   rd_ts;
	logic [LEN_W-1:0]  rd_len;

	kbt_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	kbt_ram #(.WIDTH(BYTE_W), .DEPTH(PAY_DEPTH)) u_payload (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	assign rd_key    = m_rdata[META_W-1 -: KEY_W];
	assign rd_ts     = m_rdata[LEN_W +: TS_W];
	assign rd_len    = m_rdata[LEN_W-1:0];
	assign key_hit   = (rd_key == req_q.key);
	assign len_ok    = (req.len >= LEN_W'(MIN_LEN)) && (req.len <= LEN_W'(MAX_LEN));
	assign scan_done = found_q || ((addr_q == ENT_CNT) && !rd_vld_s1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (req.cmd)
						CMD_LOOKUP:          state_d = ST_SCAN;
						CMD_STORE:           state_d = len_ok ? ST_SCAN : ST_DONE;
						CMD_WRITE, CMD_READ: state_d = ST_ACC;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_done) state_d = (req_q.cmd == CMD_STORE) ? ST_UPDATE : ST_DONE;
			end
			ST_UPDATE:  state_d = ST_DONE;
			ST_ACC:     state_d = ST_ACC_RSP;
			ST_ACC_RSP: state_d = ST_DONE;
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		m_we    = 1'b0;
		m_waddr = chosen_q;
		m_wdata = {req_q.key, req_q.ts, req_q.len};
		m_raddr = addr_q[IDX_W-1:0];
		p_we    = 1'b0;
		p_waddr = {cur_q, req_q.bidx};
		p_wdata = req_q.bval;
		p_raddr = {cur_q, req_q.bidx};
		issue   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = clr_q[PAY_AW-1 -: IDX_W];
				m_wdata = '0;
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = '0;
			end
			ST_SCAN: begin
				issue = !found_q && (addr_q < ENT_CNT);
			end
			ST_UPDATE: begin
				m_we = 1'b1;
			end
			ST_ACC: begin
				m_raddr = cur_q;
				p_we    = (req_q.cmd == CMD_WRITE);
			end
			ST_IDLE, ST_ACC_RSP, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			addr_q    <= '0;
			found_q   <= 1'b0;
			cur_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_IDLE) begin
				addr_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (issue) addr_q <= addr_q + 1'b1;
				if (rd_vld_s1 && !found_q && key_hit) found_q <= 1'b1;
				if (scan_done && found_q && req_q.cmd == CMD_LOOKUP) cur_q <= chosen_q;
			end else if (state_q == ST_UPDATE) begin
				cur_q <= chosen_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_q <= '{cmd: req.cmd, key: req.key & KEY_MASK, ts: req.ts,
					           len: req.len, bidx: req.bidx, bval: req.bval};
				end
				min_q    <= TIME_INIT;
				chosen_q <= '0;
				res_q    <= '{status: STS_REJECT, slot: '0, blen: '0, rbyte: '0};
			end
			ST_SCAN: begin
				if (rd_vld_s1 && !found_q) begin
					if (key_hit) begin
						chosen_q  <= rd_idx_s1;
						hit_len_q <= rd_len;
					end else if (req_q.cmd == CMD_STORE && rd_ts < min_q) begin
						min_q    <= rd_ts;
						chosen_q <= rd_idx_s1;
					end
				end
				if (scan_done) begin
					if (found_q) begin
						res_q <= '{status: STS_OK, slot: SLOT_W'(chosen_q),
						           blen: hit_len_q, rbyte: '0};
					end else begin
						res_q <= '{status: STS_MISS, slot: '0, blen: '0, rbyte: '0};
					end
				end
			end
			ST_UPDATE: begin
				res_q <= '{status: STS_OK, slot: SLOT_W'(chosen_q),
				           blen: req_q.len, rbyte: '0};
			end
			ST_ACC_RSP: begin
				res_q <= '{status: STS_OK, slot: SLOT_W'(cur_q), blen: rd_len,
				           rbyte: (req_q.cmd == CMD_READ) ? p_rdata : '0};
			end
			ST_CLEAR, ST_ACC, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign ready     = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

endmodule

`default_nettype wire

// File: sv/kbt_checker.sv
`default_nettype none

module kbt_checker import kbt_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [STS_W-1:0]      m_tuser
);

	// output beat holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed under stall");

	// one command in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat taken while busy");

	// miss and reject carry no slot, length or byte
	a_zero_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STS_MISS || m_tuser == STS_REJECT) |-> m_tdata == '0)
		else $error("nonzero data on miss or reject");

endmodule

bind keyed_blob_table_oldest_evict kbt_checker u_kbt_checker (.*);

`default_nettype wire
